FILE: hdl/rss_pkg.sv
// shared constants, types and the half-angle sine table of the range scan segmenter
`default_nettype none

package rss_pkg;

    // sweep and sine settings
    localparam int SWEEP_END      = 180;
    localparam int SINE_FRAC_BITS = 15;
    localparam int SINE_W         = SINE_FRAC_BITS + 1;
    localparam int SINE_Q         = 30;
    localparam int SINE_ENTRIES   = 181;
    localparam int SINE_IDX_W     = $clog2(SINE_ENTRIES);
    localparam int TAYLOR_TERMS   = 7;
    localparam longint HALF_DEG_Q30 = 9370165;
    localparam longint TAYLOR_DIV [1:TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210};

    // field widths
    localparam int ANGLE_W  = 8;
    localparam int SONAR_W  = 10;
    localparam int IR_W     = 12;
    localparam int LIMIT_W  = 10;
    localparam int AOFF_W   = 8;
    localparam int DOFF_W   = 6;
    localparam int MINW_W   = 7;
    localparam int CENTER_W = 8;
    localparam int DIST_W   = 11;
    localparam int WIDTH_W  = 10;
    localparam int COUNT_W  = 7;
    localparam int SUM_W    = 17;
    localparam int SPAN_W   = 10;
    localparam int IR_PROD_W = LIMIT_W + 2 * IR_W;

    // stream and register port widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - (CENTER_W + DIST_W + WIDTH_W + COUNT_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // serial multiplier: mcand holds r, r*r or sum, mplier holds r, limit-10 or the sine
    localparam int MUL_A_W   = 2 * IR_W;
    localparam int MUL_B_W   = SINE_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // serial divider: numerator up to 2*sum+cnt, divisor up to 2*cnt
    localparam int DIV_N_W   = SUM_W + 1;
    localparam int DIV_D_W   = COUNT_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam logic [IR_PROD_W-1:0] IR_SCALE  = IR_PROD_W'(16820000);
    localparam logic [LIMIT_W-1:0]   IR_BIAS   = LIMIT_W'(10);
    localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [WIDTH_W-1:0]   WIDTH_MAX = {WIDTH_W{1'b1}};
    localparam logic [SPAN_W-1:0]    SINE_FOLD = SPAN_W'(SINE_ENTRIES - 1);

    // register reset values
    localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RST = LIMIT_W'(100);
    localparam logic [AOFF_W-1:0]  ANGLE_OFF_RST  = AOFF_W'(-10);
    localparam logic [DOFF_W-1:0]  DIST_OFF_RST   = DOFF_W'(10);
    localparam logic [MINW_W-1:0]  MIN_WIDTH_RST  = MINW_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_LIMIT   = 2'd0,
        CFG_ANGLE_OFFSET = 2'd1,
        CFG_DIST_OFFSET  = 2'd2,
        CFG_MIN_WIDTH    = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_DETECTED = 2'd1,
        MODE_TRACKING = 2'd2
    } t_track_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SCALE,
        ST_DECIDE,
        ST_WMUL,
        ST_MEAN,
        ST_WDIV,
        ST_PUSH
    } t_seq_state;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] mcand;
        logic [MUL_B_W-1:0] mplier;
    } t_mul_cmd;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

    typedef logic [SINE_ENTRIES-1:0][SINE_W-1:0] t_sine_rom;

    // |sin(a/2 deg)| by a truncated odd series in Q2.30, rounded to SINE_FRAC_BITS
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint    x;
        longint    x2;
        longint    term;
        longint    acc;
        for (int idx = 0; idx < SINE_ENTRIES; idx++) begin
            x    = longint'(idx) * HALF_DEG_Q30;
            x2   = (x * x) >>> SINE_Q;
            term = x;
            acc  = x;
            for (int k = 1; k <= TAYLOR_TERMS; k++) begin
                term = (term * x2) >>> SINE_Q;
                term = term / TAYLOR_DIV[k];
                if (k[0]) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            acc = (acc + (longint'(1) <<< (SINE_Q - SINE_FRAC_BITS - 1)))
                  >>> (SINE_Q - SINE_FRAC_BITS);
            rom[idx] = acc[SINE_W-1:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

FILE: hdl/rss_serial_mult.sv
// shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module rss_serial_mult (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rss_pkg::t_mul_cmd             i_cmd,
    output rss_pkg::t_unit_status              o_status,
    output logic [rss_pkg::MUL_P_W-1:0]        o_product
);

    logic                            r_busy;
    logic                            r_done;
    logic [rss_pkg::MUL_CNT_W-1:0]   r_cnt;
    logic [rss_pkg::MUL_A_W-1:0]     r_mcand;
    logic [rss_pkg::MUL_A_W-1:0]     r_hi;
    logic [rss_pkg::MUL_B_W-1:0]     r_lo;

    logic [rss_pkg::MUL_A_W-1:0]     addend;
    logic [rss_pkg::MUL_A_W:0]       step_sum;

    assign addend   = r_lo[0] ? r_mcand : '0;
    assign step_sum = {1'b0, r_hi} + {1'b0, addend};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rss_pkg::MUL_CNT_W'(rss_pkg::MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // low word shifts the multiplier out and the product bits in
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mcand <= i_cmd.mcand;
            r_hi    <= '0;
            r_lo    <= i_cmd.mplier;
        end else if (r_busy) begin
            r_hi <= step_sum[rss_pkg::MUL_A_W:1];
            r_lo <= {step_sum[0], r_lo[rss_pkg::MUL_B_W-1:1]};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_product     = {r_hi, r_lo};

endmodule

`default_nettype wire

FILE: hdl/rss_serial_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module rss_serial_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rss_pkg::t_div_cmd             i_cmd,
    output rss_pkg::t_unit_status              o_status,
    output logic [rss_pkg::DIV_N_W-1:0]        o_quotient
);

    logic                            r_busy;
    logic                            r_done;
    logic [rss_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [rss_pkg::DIV_D_W-1:0]     r_divisor;
    logic [rss_pkg::DIV_D_W-1:0]     r_rem;
    logic [rss_pkg::DIV_N_W-1:0]     r_quo;

    logic [rss_pkg::DIV_D_W:0]       trial;
    logic [rss_pkg::DIV_D_W+1:0]     diff;
    logic                            fits;

    assign trial = {r_rem, r_quo[rss_pkg::DIV_N_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_divisor};
    assign fits  = !diff[rss_pkg::DIV_D_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rss_pkg::DIV_CNT_W'(rss_pkg::DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_divisor <= i_cmd.divisor;
            r_rem     <= '0;
            r_quo     <= i_cmd.dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[rss_pkg::DIV_D_W-1:0] : trial[rss_pkg::DIV_D_W-1:0];
            r_quo <= {r_quo[rss_pkg::DIV_N_W-2:0], fits};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

`default_nettype wire

FILE: hdl/range_scan_object_segmenter.sv
// top level: sweep sample intake, near/far test, object tracking and report
// Takes one sweep sample at a time (angle, sonar range, raw IR reading, scan-start flag in
// tuser) and emits one report when a tracked object ends. A sample at or past the sweep end
// leaves the block idle; a sample with a zero IR reading or a near limit of 10 or less
// goes straight to the near/far decision; any other sample first makes two passes through
// the one-bit-per-cycle multiplier (16 steps each) that form (near_limit-10)*r*r. A sample
// that closes an object adds a multiplier pass for sum*sine and two 18-step divider passes
// for the mean and the width, plus any wait for a stalled report to leave the output
// register. The input is ready again as soon as a report sits in the output register.
// Configuration writes are taken in any cycle and are meant for an idle block.
`default_nettype none

module range_scan_object_segmenter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // sweep_angle[7:0], sonar_cm[17:8], ir_raw[29:18], zero[31:30]
    input  wire logic [rss_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // scan_start
    input  wire logic                              i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // center_angle[7:0], reported_distance[18:8], linear_width[28:19],
    // object_number[35:29], zero[39:36]
    output logic [rss_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rss_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // configuration
    logic [rss_pkg::LIMIT_W-1:0]  r_near_limit;
    logic [rss_pkg::AOFF_W-1:0]   r_angle_off;
    logic [rss_pkg::DOFF_W-1:0]   r_dist_off;
    logic [rss_pkg::MINW_W-1:0]   r_min_width;

    // tracking state
    rss_pkg::t_seq_state          r_state;
    rss_pkg::t_seq_state          n_state;
    rss_pkg::t_track_mode         r_mode;
    logic [rss_pkg::ANGLE_W-1:0]  r_start_angle;
    logic [rss_pkg::SUM_W-1:0]    r_dist_sum;
    logic [rss_pkg::COUNT_W-1:0]  r_hit_count;
    logic [rss_pkg::COUNT_W-1:0]  r_objects;

    // current sample
    logic [rss_pkg::ANGLE_W-1:0]  r_angle;
    logic [rss_pkg::SONAR_W-1:0]  r_sonar;
    logic                         r_ir_near;
    logic                         r_ir_far;
    logic [rss_pkg::WIDTH_W-1:0]  r_mean;

    logic                         r_m_valid;
    logic [rss_pkg::OUT_DATA_W-1:0] r_m_data;

    logic                         in_accept;
    logic [rss_pkg::ANGLE_W-1:0]  in_angle;
    logic [rss_pkg::SONAR_W-1:0]  in_sonar;
    logic [rss_pkg::IR_W-1:0]     in_ir;
    logic                         in_range;
    logic                         ir_shortcut;

    logic [rss_pkg::LIMIT_W-1:0]  limit_m;
    logic                         near_both;
    logic                         far_any;
    logic [rss_pkg::COUNT_W-1:0]  cnt_eff;
    logic [rss_pkg::IR_PROD_W-1:0] ir_prod;

    logic [rss_pkg::SPAN_W-1:0]   span_s;
    logic [rss_pkg::SPAN_W-1:0]   span_abs;
    logic [rss_pkg::SPAN_W-1:0]   span_fold;
    logic [rss_pkg::SINE_W-1:0]   sine_val;

    logic [rss_pkg::SUM_W+rss_pkg::SINE_W:0] width_q;
    logic [rss_pkg::DIV_N_W-1:0]  mean_num;
    logic [rss_pkg::DIV_N_W-1:0]  width_num;

    logic [rss_pkg::ANGLE_W:0]    angle_pair;
    logic [rss_pkg::SPAN_W-1:0]   center_s;
    logic [rss_pkg::CENTER_W-1:0] center_out;
    logic [rss_pkg::DIST_W-1:0]   dist_out;
    logic [rss_pkg::WIDTH_W-1:0]  width_out;
    logic [rss_pkg::OUT_DATA_W-1:0] out_word;

    logic [rss_pkg::SUM_W-1:0]    acc_sum;
    logic [rss_pkg::COUNT_W-1:0]  acc_hit;

    rss_pkg::t_mul_cmd            mul_cmd;
    rss_pkg::t_unit_status        mul_st;
    logic [rss_pkg::MUL_P_W-1:0]  mul_product;
    rss_pkg::t_div_cmd            div_cmd;
    rss_pkg::t_unit_status        div_st;
    logic [rss_pkg::DIV_N_W-1:0]  div_quo;

    logic                         ir_test_done;
    logic                         mean_load;
    logic                         push;

    rss_serial_mult u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mul_cmd),
        .o_status  (mul_st),
        .o_product (mul_product)
    );

    rss_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (div_cmd),
        .o_status   (div_st),
        .o_quotient (div_quo)
    );

    assign o_s_axis_tready = (r_state == rss_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign in_accept       = i_s_axis_tvalid & o_s_axis_tready;

    assign in_angle = i_s_axis_tdata[7:0];
    assign in_sonar = i_s_axis_tdata[17:8];
    assign in_ir    = i_s_axis_tdata[29:18];
    assign in_range = rss_pkg::SPAN_W'(in_angle) < rss_pkg::SPAN_W'(rss_pkg::SWEEP_END);

    // a zero reading or a limit of 10 or less makes the IR product at most zero: always far
    assign ir_shortcut = (in_ir == '0) || (r_near_limit <= rss_pkg::IR_BIAS);
    assign limit_m     = r_near_limit - rss_pkg::IR_BIAS;
    assign ir_prod     = mul_product[rss_pkg::IR_PROD_W-1:0];

    assign near_both = (r_sonar < r_near_limit) && r_ir_near;
    assign far_any   = (r_sonar > r_near_limit) || r_ir_far;
    assign cnt_eff   = (r_hit_count != '0) ? r_hit_count : rss_pkg::COUNT_W'(1);

    // span folded to 0..180 for the sine table
    assign span_s    = rss_pkg::SPAN_W'(r_angle) - rss_pkg::SPAN_W'(r_start_angle)
                       - rss_pkg::SPAN_W'(2);
    assign span_abs  = span_s[rss_pkg::SPAN_W-1] ? (~span_s + 1'b1) : span_s;
    assign span_fold = (span_abs > rss_pkg::SINE_FOLD) ? ((rss_pkg::SINE_FOLD << 1) - span_abs)
                                                      : span_abs;
    assign sine_val  = rss_pkg::SINE_ROM[span_fold[rss_pkg::SINE_IDX_W-1:0]];

    assign mean_num  = rss_pkg::DIV_N_W'({r_dist_sum, 1'b0}) + rss_pkg::DIV_N_W'(cnt_eff);
    assign width_q   = (rss_pkg::SUM_W+rss_pkg::SINE_W+1)'(
                           mul_product[rss_pkg::SUM_W+rss_pkg::SINE_W-1:0])
                     + ((rss_pkg::SUM_W+rss_pkg::SINE_W+1)'(cnt_eff)
                        << (rss_pkg::SINE_FRAC_BITS - 1));
    assign width_num = width_q[rss_pkg::SINE_FRAC_BITS +: rss_pkg::DIV_N_W];

    // report fields
    assign angle_pair = {1'b0, r_start_angle} + {1'b0, r_angle};
    assign center_s   = rss_pkg::SPAN_W'(angle_pair[rss_pkg::ANGLE_W:1])
                        - rss_pkg::SPAN_W'(2)
                        + {{(rss_pkg::SPAN_W-rss_pkg::AOFF_W){r_angle_off[rss_pkg::AOFF_W-1]}},
                           r_angle_off};
    always_comb begin
        if (center_s[rss_pkg::SPAN_W-1] || center_s == '0) begin
            center_out = '0;
        end else if (center_s[rss_pkg::SPAN_W-2:rss_pkg::CENTER_W] != '0) begin
            center_out = '1;
        end else begin
            center_out = center_s[rss_pkg::CENTER_W-1:0];
        end
    end

    assign dist_out = rss_pkg::DIST_W'(r_mean) - rss_pkg::DIST_W'(r_dist_off);

    always_comb begin
        if (div_quo < rss_pkg::DIV_N_W'(r_min_width)) begin
            width_out = rss_pkg::WIDTH_W'(r_min_width);
        end else if (div_quo > rss_pkg::DIV_N_W'(rss_pkg::WIDTH_MAX)) begin
            width_out = rss_pkg::WIDTH_MAX;
        end else begin
            width_out = div_quo[rss_pkg::WIDTH_W-1:0];
        end
    end

    assign out_word = {{rss_pkg::OUT_PAD_W{1'b0}}, r_objects, width_out, dist_out, center_out};

    // saturating accumulate of the current sonar reading
    always_comb begin
        if (r_hit_count < rss_pkg::COUNT_MAX) begin
            acc_sum = r_dist_sum + rss_pkg::SUM_W'(r_sonar);
            acc_hit = r_hit_count + 1'b1;
        end else begin
            acc_sum = r_dist_sum;
            acc_hit = r_hit_count;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rss_pkg::ST_IDLE: begin
                if (in_accept && in_range) begin
                    n_state = ir_shortcut ? rss_pkg::ST_DECIDE : rss_pkg::ST_SQUARE;
                end
            end
            rss_pkg::ST_SQUARE: begin
                if (mul_st.done) begin
                    n_state = rss_pkg::ST_SCALE;
                end
            end
            rss_pkg::ST_SCALE: begin
                if (mul_st.done) begin
                    n_state = rss_pkg::ST_DECIDE;
                end
            end
            rss_pkg::ST_DECIDE: begin
                if (r_mode == rss_pkg::MODE_TRACKING && far_any) begin
                    n_state = rss_pkg::ST_WMUL;
                end else begin
                    n_state = rss_pkg::ST_IDLE;
                end
            end
            rss_pkg::ST_WMUL: begin
                if (mul_st.done) begin
                    n_state = rss_pkg::ST_MEAN;
                end
            end
            rss_pkg::ST_MEAN: begin
                if (!div_st.busy) begin
                    n_state = rss_pkg::ST_WDIV;
                end
            end
            rss_pkg::ST_WDIV: begin
                if (div_st.done) begin
                    n_state = rss_pkg::ST_PUSH;
                end
            end
            rss_pkg::ST_PUSH: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_state = rss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rss_pkg::ST_IDLE;
            end
        endcase
    end

    // unit commands and strobes
    always_comb begin
        mul_cmd      = '0;
        div_cmd      = '0;
        ir_test_done = 1'b0;
        mean_load    = 1'b0;
        push         = 1'b0;
        case (r_state)
            rss_pkg::ST_IDLE: begin
                if (in_accept && in_range && !ir_shortcut) begin
                    mul_cmd.start  = 1'b1;
                    mul_cmd.mcand  = rss_pkg::MUL_A_W'(in_ir);
                    mul_cmd.mplier = rss_pkg::MUL_B_W'(in_ir);
                end
            end
            rss_pkg::ST_SQUARE: begin
                if (mul_st.done) begin
                    mul_cmd.start  = 1'b1;
                    mul_cmd.mcand  = mul_product[rss_pkg::MUL_A_W-1:0];
                    mul_cmd.mplier = rss_pkg::MUL_B_W'(limit_m);
                end
            end
            rss_pkg::ST_SCALE: begin
                ir_test_done = mul_st.done;
            end
            rss_pkg::ST_DECIDE: begin
                if (r_mode == rss_pkg::MODE_TRACKING && far_any) begin
                    mul_cmd.start    = 1'b1;
                    mul_cmd.mcand    = rss_pkg::MUL_A_W'(r_dist_sum);
                    mul_cmd.mplier   = sine_val;
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = mean_num;
                    div_cmd.divisor  = {cnt_eff, 1'b0};
                end
            end
            rss_pkg::ST_MEAN: begin
                if (!div_st.busy) begin
                    mean_load        = 1'b1;
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = width_num;
                    div_cmd.divisor  = rss_pkg::DIV_D_W'(cnt_eff);
                end
            end
            rss_pkg::ST_PUSH: begin
                push = !r_m_valid || i_m_axis_tready;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rss_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_limit <= rss_pkg::NEAR_LIMIT_RST;
            r_angle_off  <= rss_pkg::ANGLE_OFF_RST;
            r_dist_off   <= rss_pkg::DIST_OFF_RST;
            r_min_width  <= rss_pkg::MIN_WIDTH_RST;
        end else if (i_cfg_valid) begin
            case (rss_pkg::t_cfg_index'(i_cfg_index))
                rss_pkg::CFG_NEAR_LIMIT:   r_near_limit <= i_cfg_data[rss_pkg::LIMIT_W-1:0];
                rss_pkg::CFG_ANGLE_OFFSET: r_angle_off  <= i_cfg_data[rss_pkg::AOFF_W-1:0];
                rss_pkg::CFG_DIST_OFFSET:  r_dist_off   <= i_cfg_data[rss_pkg::DOFF_W-1:0];
                rss_pkg::CFG_MIN_WIDTH:    r_min_width  <= i_cfg_data[rss_pkg::MINW_W-1:0];
                default: begin
                    r_near_limit <= r_near_limit;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= rss_pkg::MODE_IDLE;
            r_start_angle <= '0;
            r_dist_sum    <= '0;
            r_hit_count   <= '0;
            r_objects     <= '0;
        end else if (in_accept && i_s_axis_tuser) begin
            r_mode        <= rss_pkg::MODE_IDLE;
            r_start_angle <= '0;
            r_dist_sum    <= '0;
            r_hit_count   <= '0;
            r_objects     <= '0;
        end else if (r_state == rss_pkg::ST_DECIDE) begin
            case (r_mode)
                rss_pkg::MODE_DETECTED: begin
                    if (near_both) begin
                        r_dist_sum  <= acc_sum;
                        r_hit_count <= acc_hit;
                        r_mode      <= rss_pkg::MODE_TRACKING;
                    end
                end
                rss_pkg::MODE_TRACKING: begin
                    if (!far_any && near_both) begin
                        r_dist_sum  <= acc_sum;
                        r_hit_count <= acc_hit;
                    end
                end
                default: begin
                    // new object: first hit opens the run
                    if (near_both) begin
                        r_mode        <= rss_pkg::MODE_DETECTED;
                        r_start_angle <= r_angle;
                        r_dist_sum    <= rss_pkg::SUM_W'(r_sonar);
                        r_hit_count   <= rss_pkg::COUNT_W'(1);
                        if (r_objects < rss_pkg::COUNT_MAX) begin
                            r_objects <= r_objects + 1'b1;
                        end
                    end
                end
            endcase
        end else if (push) begin
            r_mode        <= rss_pkg::MODE_IDLE;
            r_start_angle <= '0;
            r_dist_sum    <= '0;
            r_hit_count   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_angle   <= in_angle;
            r_sonar   <= in_sonar;
            r_ir_near <= 1'b0;
            r_ir_far  <= 1'b1;
        end else if (ir_test_done) begin
            r_ir_near <= ir_prod > rss_pkg::IR_SCALE;
            r_ir_far  <= ir_prod < rss_pkg::IR_SCALE;
        end
        if (mean_load) begin
            r_mean <= div_quo[rss_pkg::WIDTH_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (push) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_m_data <= out_word;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

FILE: hdl/rss_checker.sv
// port-level checks of the range scan segmenter, bound to the top level
`default_nettype none

module rss_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [rss_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    // a stalled report keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("report changed while stalled");

    // report padding stays zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[39:36] == 4'd0)
        else $error("report padding not zero");

    // every report belongs to a counted object
    a_obj_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[35:29] != 7'd0)
        else $error("report with object number zero");

    // a mean distance less at most 63 never goes below -64
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[18] |-> o_m_axis_tdata[18:14] == 5'b11111)
        else $error("reported distance out of range");

    // a report needs the serial units, so none shows up right after a transfer in
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !$rose(o_m_axis_tvalid))
        else $error("report right after input transfer");

endmodule

bind range_scan_object_segmenter rss_checker u_rss_checker (.*);

`default_nettype wire
